// File: design/mips_integer_instruction_execute_assert.svh
// ----------------------------------------------------------------------------
// mips integer execute assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef MIPS_INTEGER_INSTRUCTION_EXECUTE_ASSERT_SVH
`define MIPS_INTEGER_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define MIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mie assertion failed");

// next-cycle implication, ignored while in reset
`define MIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mie assertion failed");

// next-cycle implication, also checked across reset
`define MIE_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mie assertion failed");

`endif

// File: design/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// opcodes, function codes, status codes and pipeline types of the execute block
// ----------------------------------------------------------------------------
package mie_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_MISALIGNED = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;
  localparam logic [4:0] REG_RA  = 5'd31;

  // access sizes in bytes
  localparam logic [2:0] SZ_NONE = 3'd0;
  localparam logic [2:0] SZ_BYTE = 3'd1;
  localparam logic [2:0] SZ_HALF = 3'd2;
  localparam logic [2:0] SZ_WORD = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] instruction;
    logic [11:0] load_address;
    logic [31:0] load_data;
  } s1_t;

  typedef struct packed {
    logic [31:0] pc;
    status_t     st;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        load;
    logic [2:0]  size;
    logic        sext;
    logic [1:0]  off;
  } s2_t;

endpackage

// File: design/mips_integer_instruction_execute.sv
// ----------------------------------------------------------------------------
// mips_integer_instruction_execute
// MIPS-I integer execute block with register file, byte memory and pc
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// in       | in_valid, in_stall | kind, instruction, load_address, load_data
// out      | out_valid,out_stall| pc_after, status, reg_written, reg_index,
//          |                    | reg_value
//
// one item per cycle sustained unless out_stall backs up; an accepted item is
// registered in s1, then decode/execute with memory port, then result register.
// operands are forwarded from the two items ahead, so no hazard stalls.
// reset clears pc, register file valid bits and all stage valids; memory is
// not cleared. out_stall freezes only the stages that are full behind it.
module mips_integer_instruction_execute #(
  parameter int MEMORY_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] instruction,
  input  logic [11:0] load_address,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pc_after,
  output logic [1:0]  status,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value
);

  localparam int DEPTH = (MEMORY_BYTES + 3) / 4;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [32:0] MEM_LIMIT = 33'(MEMORY_BYTES);

  // pipeline control
  logic s1_v, s2_v;
  logic o_adv, s2_adv, in_accept, s1_hold;
  mie_pkg::s1_t s1;
  mie_pkg::s2_t s2, s2_next;

  assign o_adv     = s2_v && (!out_valid || !out_stall);
  assign s2_adv    = s1_v && (!s2_v || o_adv);
  assign s1_hold   = s1_v && !s2_adv;
  assign in_stall  = s1_hold;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v      <= in_accept || s1_hold;
      s2_v      <= s2_adv || (s2_v && !o_adv);
      out_valid <= o_adv || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1.kind         <= kind;
      s1.instruction  <= instruction;
      s1.load_address <= load_address;
      s1.load_data    <= load_data;
    end
  end

  // register file: read every cycle at the item that will sit in s1
  logic [31:0] rf [32];
  logic [31:0] rf_ok;
  logic [31:0] rf_a, rf_b;
  logic        ok_a, ok_b;
  logic [4:0]  ra, rb;
  logic [31:0] s2_val;

  assign ra = s1_hold ? s1.instruction[25:21] : instruction[25:21];
  assign rb = s1_hold ? s1.instruction[20:16] : instruction[20:16];

  always_ff @(posedge clk) begin
    rf_a <= rf[ra];
    rf_b <= rf[rb];
    ok_a <= rf_ok[ra];
    ok_b <= rf_ok[rb];
    if (o_adv && s2.wr) begin
      rf[s2.idx] <= s2_val;
    end
  end

  // last committed write, covers a commit on the same edge as the read
  logic        lw_v;
  logic [4:0]  lw_idx;
  logic [31:0] lw_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok <= '0;
      lw_v  <= 1'b0;
    end else if (o_adv && s2.wr) begin
      rf_ok[s2.idx] <= 1'b1;
      lw_v          <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && s2.wr) begin
      lw_idx <= s2.idx;
      lw_val <= s2_val;
    end
  end

  // operand forwarding, newest first; $0 is never written so reads zero
  logic [4:0]  rs, rt, rd, sa;
  logic [5:0]  op, fn;
  logic [31:0] a, b;

  assign op = s1.instruction[31:26];
  assign rs = s1.instruction[25:21];
  assign rt = s1.instruction[20:16];
  assign rd = s1.instruction[15:11];
  assign sa = s1.instruction[10:6];
  assign fn = s1.instruction[5:0];

  always_comb begin
    priority if (s2_v && s2.wr && s2.idx == rs) a = s2_val;
    else if (lw_v && lw_idx == rs)              a = lw_val;
    else                                        a = ok_a ? rf_a : 32'd0;
    priority if (s2_v && s2.wr && s2.idx == rt) b = s2_val;
    else if (lw_v && lw_idx == rt)              b = lw_val;
    else                                        b = ok_b ? rf_b : 32'd0;
  end

  // execute
  logic [31:0] program_counter;
  logic [31:0] imm, simm, pc4, target, addr, sdata;
  logic        store;

  assign imm    = {16'd0, s1.instruction[15:0]};
  assign simm   = {{16{s1.instruction[15]}}, s1.instruction[15:0]};
  assign pc4    = program_counter + 32'd4;
  assign target = pc4 + {simm[29:0], 2'b00};

  always_comb begin
    mie_pkg::status_t st;
    logic        wr, lez;
    logic [4:0]  dst;
    logic [31:0] val, npc;
    logic [2:0]  size;
    logic        sext;
    st    = mie_pkg::ST_OK;
    wr    = 1'b0;
    dst   = 5'd0;
    val   = 32'd0;
    npc   = program_counter;
    size  = mie_pkg::SZ_NONE;
    sext  = 1'b0;
    store = 1'b0;
    addr  = a + simm;
    sdata = b;
    lez   = (a == 32'd0) || a[31];
    if (s1.kind) begin
      addr  = {20'd0, s1.load_address};
      size  = mie_pkg::SZ_WORD;
      store = 1'b1;
      sdata = s1.load_data;
    end else begin
      npc = pc4;
      unique case (op)
        mie_pkg::OP_SPECIAL: begin
          wr  = 1'b1;
          dst = rd;
          if (fn == mie_pkg::FN_SLL || fn == mie_pkg::FN_SRL || fn == mie_pkg::FN_SRA) begin
            if (rs != 5'd0) st = mie_pkg::ST_UNKNOWN;
            else if (fn == mie_pkg::FN_SLL) val = b << sa;
            else if (fn == mie_pkg::FN_SRL) val = b >> sa;
            else val = 32'($signed(b) >>> sa);
          end else if (sa != 5'd0) begin
            st = mie_pkg::ST_UNKNOWN;
          end else begin
            unique case (fn)
              mie_pkg::FN_SLLV: val = b << a[4:0];
              mie_pkg::FN_SRLV: val = b >> a[4:0];
              mie_pkg::FN_SRAV: val = 32'($signed(b) >>> a[4:0]);
              mie_pkg::FN_JR: begin
                if (rt != 5'd0 || rd != 5'd0) st = mie_pkg::ST_UNKNOWN;
                else begin
                  wr  = 1'b0;
                  npc = a;
                end
              end
              mie_pkg::FN_JALR: begin
                if (rt != 5'd0) st = mie_pkg::ST_UNKNOWN;
                else begin
                  val = pc4 + 32'd4;
                  npc = a;
                end
              end
              mie_pkg::FN_ADD, mie_pkg::FN_ADDU: val = a + b;
              mie_pkg::FN_SUB, mie_pkg::FN_SUBU: val = a - b;
              mie_pkg::FN_AND:  val = a & b;
              mie_pkg::FN_OR:   val = a | b;
              mie_pkg::FN_XOR:  val = a ^ b;
              mie_pkg::FN_NOR:  val = ~(a | b);
              mie_pkg::FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
              mie_pkg::FN_SLTU: val = {31'd0, a < b};
              default: st = mie_pkg::ST_UNKNOWN;
            endcase
          end
        end
        mie_pkg::OP_REGIMM: begin
          if (rt == mie_pkg::RT_BGEZ) begin
            if (!a[31]) npc = target;
          end else if (rt == mie_pkg::RT_BLTZ) begin
            if (a[31]) npc = target;
          end else begin
            st = mie_pkg::ST_UNKNOWN;
          end
        end
        mie_pkg::OP_J: npc = {pc4[31:28], s1.instruction[25:0], 2'b00};
        mie_pkg::OP_JAL: begin
          wr  = 1'b1;
          dst = mie_pkg::REG_RA;
          val = pc4 + 32'd4;
          npc = {pc4[31:28], s1.instruction[25:0], 2'b00};
        end
        mie_pkg::OP_BEQ: if (a == b) npc = target;
        mie_pkg::OP_BNE: if (a != b) npc = target;
        mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ: begin
          if (rt != 5'd0) st = mie_pkg::ST_UNKNOWN;
          else if (lez == (op == mie_pkg::OP_BLEZ)) npc = target;
        end
        mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin
          wr = 1'b1; dst = rt; val = a + simm;
        end
        mie_pkg::OP_SLTI: begin
          wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(simm)};
        end
        mie_pkg::OP_SLTIU: begin
          wr = 1'b1; dst = rt; val = {31'd0, a < simm};
        end
        mie_pkg::OP_ANDI: begin wr = 1'b1; dst = rt; val = a & imm; end
        mie_pkg::OP_ORI:  begin wr = 1'b1; dst = rt; val = a | imm; end
        mie_pkg::OP_XORI: begin wr = 1'b1; dst = rt; val = a ^ imm; end
        mie_pkg::OP_LUI: begin
          if (rs != 5'd0) st = mie_pkg::ST_UNKNOWN;
          else begin
            wr = 1'b1; dst = rt; val = {s1.instruction[15:0], 16'd0};
          end
        end
        mie_pkg::OP_LB:  begin size = mie_pkg::SZ_BYTE; sext = 1'b1; end
        mie_pkg::OP_LH:  begin size = mie_pkg::SZ_HALF; sext = 1'b1; end
        mie_pkg::OP_LW:  size = mie_pkg::SZ_WORD;
        mie_pkg::OP_LBU: size = mie_pkg::SZ_BYTE;
        mie_pkg::OP_LHU: size = mie_pkg::SZ_HALF;
        mie_pkg::OP_SB:  begin size = mie_pkg::SZ_BYTE; store = 1'b1; end
        mie_pkg::OP_SH:  begin size = mie_pkg::SZ_HALF; store = 1'b1; end
        mie_pkg::OP_SW:  begin size = mie_pkg::SZ_WORD; store = 1'b1; end
        default: st = mie_pkg::ST_UNKNOWN;
      endcase
    end

    if (st == mie_pkg::ST_OK && size != mie_pkg::SZ_NONE) begin
      if ((size == mie_pkg::SZ_HALF && addr[0]) ||
          (size == mie_pkg::SZ_WORD && addr[1:0] != 2'b00)) begin
        st = mie_pkg::ST_MISALIGNED;
      end else if ({1'b0, addr} + {30'd0, size} > MEM_LIMIT) begin
        st = mie_pkg::ST_RANGE;
      end else if (!store) begin
        wr  = 1'b1;
        dst = rt;
      end
    end
    if (st != mie_pkg::ST_OK) begin
      wr    = 1'b0;
      store = 1'b0;
    end
    if (!wr || dst == 5'd0) begin
      wr  = 1'b0;
      dst = 5'd0;
      val = 32'd0;
    end

    s2_next.pc   = npc;
    s2_next.st   = st;
    s2_next.wr   = wr;
    s2_next.idx  = dst;
    s2_next.val  = val;
    s2_next.load = wr && size != mie_pkg::SZ_NONE;
    s2_next.size = size;
    s2_next.sext = sext;
    s2_next.off  = addr[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= 32'd0;
    end else if (s2_adv) begin
      program_counter <= s2_next.pc;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2 <= s2_next;
    end
  end

  // data memory: four byte lanes, one word row per aligned address
  logic [3:0][7:0] mem [DEPTH];
  logic [3:0][7:0] mem_rd;
  logic [3:0][7:0] wdata;
  logic [3:0]      be;
  logic [IDXW-1:0] midx;

  assign midx = addr[IDXW+1:2];

  always_comb begin
    unique case (s2_next.size)
      mie_pkg::SZ_BYTE: begin
        wdata = {4{sdata[7:0]}};
        be    = 4'b0001 << addr[1:0];
      end
      mie_pkg::SZ_HALF: begin
        wdata = {2{sdata[15:0]}};
        be    = addr[1] ? 4'b1100 : 4'b0011;
      end
      default: begin
        wdata = sdata;
        be    = 4'b1111;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      mem_rd <= mem[midx];
      if (store) begin
        for (int i = 0; i < 4; i++) begin
          if (be[i]) mem[midx][i] <= wdata[i];
        end
      end
    end
  end

  // load alignment and extension
  always_comb begin
    logic [31:0] sh;
    sh = mem_rd >> {s2.off, 3'b000};
    if (!s2.load) begin
      s2_val = s2.val;
    end else begin
      unique case (s2.size)
        mie_pkg::SZ_BYTE: s2_val = {{24{s2.sext & sh[7]}}, sh[7:0]};
        mie_pkg::SZ_HALF: s2_val = {{16{s2.sext & sh[15]}}, sh[15:0]};
        default:          s2_val = sh;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      pc_after    <= s2.pc;
      status      <= s2.st;
      reg_written <= s2.wr;
      reg_index   <= s2.idx;
      reg_value   <= s2_val;
    end
  end

endmodule

// File: design/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker
// port-level checks on the result channel of the execute block
// ----------------------------------------------------------------------------
`include "mips_integer_instruction_execute_assert.svh"

module mie_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] pc_after,
  input logic [1:0]  status,
  input logic        reg_written,
  input logic [4:0]  reg_index,
  input logic [31:0] reg_value
);

  `MIE_ASSERT_NXT_ALL(a_rst_empty, rst, !out_valid)
  `MIE_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(pc_after) && $stable(reg_value))
  `MIE_ASSERT_IMP(a_no_write_zero, out_valid && !reg_written, reg_index == 5'd0 && reg_value == 32'd0)
  `MIE_ASSERT_IMP(a_err_no_write, out_valid && status != mie_pkg::ST_OK, !reg_written)
  `MIE_ASSERT_IMP(a_write_nonzero, out_valid && reg_written, reg_index != 5'd0)

endmodule

bind mips_integer_instruction_execute mie_checker u_mie_checker (.*);

// File: tb/sv/tb_mips_integer_instruction_execute.sv
// ----------------------------------------------------------------------------
// tb_mips_integer_instruction_execute
// drives instruction and loader items with random idling and stalls, predicts
// each result from a private copy of registers, memory and pc, and compares
// every result field in order of arrival
// ----------------------------------------------------------------------------
module tb_mips_integer_instruction_execute;

  localparam int MEM_BYTES = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [31:0]      pc;
    mie_pkg::status_t st;
    logic             wr;
    logic [4:0]       idx;
    logic [31:0]      val;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [31:0] instruction = '0;
  logic [11:0] load_address = '0;
  logic [31:0] load_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pc_after;
  logic [1:0]  status;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;

  // predicted architectural state
  logic [31:0] gpr [32];
  logic [7:0]  mem_byte [MEM_BYTES];
  bit          mem_known [MEM_BYTES];
  logic [31:0] arch_pc;
  logic [11:0] filled_words [$];

  retire_t pending_retires [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  mips_integer_instruction_execute u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .instruction(instruction),
    .load_address(load_address), .load_data(load_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .pc_after(pc_after), .status(status), .reg_written(reg_written),
    .reg_index(reg_index), .reg_value(reg_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- encoding
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa);
    return {mie_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] reg_rd(logic [4:0] i);
    return (i == 5'd0) ? 32'd0 : gpr[i];
  endfunction

  function automatic logic [2:0] access_size(logic [5:0] op);
    case (op)
      mie_pkg::OP_LB, mie_pkg::OP_LBU, mie_pkg::OP_SB: return mie_pkg::SZ_BYTE;
      mie_pkg::OP_LH, mie_pkg::OP_LHU, mie_pkg::OP_SH: return mie_pkg::SZ_HALF;
      mie_pkg::OP_LW, mie_pkg::OP_SW:                  return mie_pkg::SZ_WORD;
      default:                                         return mie_pkg::SZ_NONE;
    endcase
  endfunction

  function automatic mie_pkg::status_t access_status(logic [31:0] addr, logic [2:0] size);
    if ((addr & (size - 32'd1)) != 0) return mie_pkg::ST_MISALIGNED;
    if ({1'b0, addr} + size > 33'(MEM_BYTES)) return mie_pkg::ST_RANGE;
    return mie_pkg::ST_OK;
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic retire_t execute_item(logic k, logic [31:0] ins, logic [11:0] la,
                                           logic [31:0] ld);
    mie_pkg::status_t st = mie_pkg::ST_OK;
    logic        wr = 1'b0;
    logic [4:0]  dst = '0;
    logic [31:0] val = '0;
    logic [31:0] npc, a, b, simm, target, addr;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [2:0]  size;
    bit          is_store;
    retire_t     r;
    if (k) begin
      st = access_status({20'd0, la}, mie_pkg::SZ_WORD);
      if (st == mie_pkg::ST_OK) begin
        for (int i = 0; i < 4; i++) begin
          mem_byte[la + i] = ld[8*i +: 8];
          mem_known[la + i] = 1'b1;
        end
        filled_words.push_back(la);
      end
    end else begin
      npc = arch_pc + 32'd4;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
      rd = ins[15:11]; sa = ins[10:6]; fn = ins[5:0];
      simm = {{16{ins[15]}}, ins[15:0]};
      a = reg_rd(rs); b = reg_rd(rt);
      target = npc + (simm << 2);
      size = mie_pkg::SZ_NONE;
      is_store = 1'b0;
      case (op)
        mie_pkg::OP_SPECIAL: begin
          wr = 1'b1; dst = rd;
          if (fn == mie_pkg::FN_SLL || fn == mie_pkg::FN_SRL || fn == mie_pkg::FN_SRA) begin
            if (rs != 0) st = mie_pkg::ST_UNKNOWN;
            else if (fn == mie_pkg::FN_SLL) val = b << sa;
            else if (fn == mie_pkg::FN_SRL) val = b >> sa;
            else val = $signed(b) >>> sa;
          end else if (sa != 0) begin
            st = mie_pkg::ST_UNKNOWN;
          end else begin
            case (fn)
              mie_pkg::FN_SLLV: val = b << a[4:0];
              mie_pkg::FN_SRLV: val = b >> a[4:0];
              mie_pkg::FN_SRAV: val = $signed(b) >>> a[4:0];
              mie_pkg::FN_JR: begin
                if (rt != 0 || rd != 0) st = mie_pkg::ST_UNKNOWN;
                else begin wr = 1'b0; npc = a; end
              end
              mie_pkg::FN_JALR: begin
                if (rt != 0) st = mie_pkg::ST_UNKNOWN;
                else begin val = npc + 32'd4; npc = a; end
              end
              mie_pkg::FN_ADD, mie_pkg::FN_ADDU: val = a + b;
              mie_pkg::FN_SUB, mie_pkg::FN_SUBU: val = a - b;
              mie_pkg::FN_AND: val = a & b;
              mie_pkg::FN_OR:  val = a | b;
              mie_pkg::FN_XOR: val = a ^ b;
              mie_pkg::FN_NOR: val = ~(a | b);
              mie_pkg::FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              mie_pkg::FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
              default: st = mie_pkg::ST_UNKNOWN;
            endcase
          end
        end
        mie_pkg::OP_REGIMM: begin
          if (rt == mie_pkg::RT_BGEZ) begin if (!a[31]) npc = target; end
          else if (rt == mie_pkg::RT_BLTZ) begin if (a[31]) npc = target; end
          else st = mie_pkg::ST_UNKNOWN;
        end
        mie_pkg::OP_J, mie_pkg::OP_JAL: begin
          if (op == mie_pkg::OP_JAL) begin
            wr = 1'b1; dst = mie_pkg::REG_RA; val = npc + 32'd4;
          end
          npc = {npc[31:28], ins[25:0], 2'b00};
        end
        mie_pkg::OP_BEQ: if (a == b) npc = target;
        mie_pkg::OP_BNE: if (a != b) npc = target;
        mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ: begin
          if (rt != 0) st = mie_pkg::ST_UNKNOWN;
          else if (((a == 0) || a[31]) == (op == mie_pkg::OP_BLEZ)) npc = target;
        end
        mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin wr = 1'b1; dst = rt; val = a + simm; end
        mie_pkg::OP_SLTI: begin
          wr = 1'b1; dst = rt; val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        end
        mie_pkg::OP_SLTIU: begin wr = 1'b1; dst = rt; val = (a < simm) ? 32'd1 : 32'd0; end
        mie_pkg::OP_ANDI: begin wr = 1'b1; dst = rt; val = a & {16'd0, ins[15:0]}; end
        mie_pkg::OP_ORI:  begin wr = 1'b1; dst = rt; val = a | {16'd0, ins[15:0]}; end
        mie_pkg::OP_XORI: begin wr = 1'b1; dst = rt; val = a ^ {16'd0, ins[15:0]}; end
        mie_pkg::OP_LUI: begin
          if (rs != 0) st = mie_pkg::ST_UNKNOWN;
          else begin wr = 1'b1; dst = rt; val = {ins[15:0], 16'd0}; end
        end
        mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW, mie_pkg::OP_LBU, mie_pkg::OP_LHU:
          size = access_size(op);
        mie_pkg::OP_SB, mie_pkg::OP_SH, mie_pkg::OP_SW: begin
          size = access_size(op); is_store = 1'b1;
        end
        default: st = mie_pkg::ST_UNKNOWN;
      endcase
      if (st == mie_pkg::ST_OK && size != mie_pkg::SZ_NONE) begin
        addr = a + simm;
        st = access_status(addr, size);
        if (st == mie_pkg::ST_OK) begin
          if (is_store) begin
            for (int i = 0; i < size; i++) begin
              mem_byte[addr + i] = b[8*i +: 8];
              mem_known[addr + i] = 1'b1;
            end
          end else begin
            val = '0;
            for (int i = 0; i < size; i++) val[8*i +: 8] = mem_byte[addr + i];
            if (op == mie_pkg::OP_LB && val[7]) val[31:8] = '1;
            if (op == mie_pkg::OP_LH && val[15]) val[31:16] = '1;
            wr = 1'b1; dst = rt;
          end
        end
      end
      if (st != mie_pkg::ST_OK) wr = 1'b0;
      arch_pc = npc;
    end
    if (!wr || dst == 0) begin
      wr = 1'b0; dst = '0; val = '0;
    end else begin
      gpr[dst] = val;
    end
    r.pc = arch_pc; r.st = st; r.wr = wr; r.idx = dst; r.val = val;
    return r;
  endfunction

  // a load that would read a byte never written is turned into a store
  function automatic logic [31:0] keep_defined(logic [31:0] ins);
    logic [2:0]  size;
    logic [31:0] addr;
    logic [31:0] fixed = ins;
    size = access_size(ins[31:26]);
    if (ins[31:26] inside {mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
                           mie_pkg::OP_LBU, mie_pkg::OP_LHU}) begin
      addr = reg_rd(ins[25:21]) + {{16{ins[15]}}, ins[15:0]};
      if (access_status(addr, size) == mie_pkg::ST_OK) begin
        for (int i = 0; i < size; i++) begin
          if (!mem_known[addr + i]) begin
            fixed[31:26] = (size == mie_pkg::SZ_BYTE) ? mie_pkg::OP_SB :
                           (size == mie_pkg::SZ_HALF) ? mie_pkg::OP_SH : mie_pkg::OP_SW;
          end
        end
      end
    end
    return fixed;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_item(logic k, logic [31:0] ins, logic [11:0] la, logic [31:0] ld);
    kind <= k;
    instruction <= ins;
    load_address <= la;
    load_data <= ld;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_retires.push_back(execute_item(k, ins, la, ld));
    if (!quiet && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic exec_ins(logic [31:0] ins);
    send_item(1'b0, keep_defined(ins), 12'($urandom), $urandom);
  endtask

  task automatic loader_write(logic [11:0] la, logic [31:0] ld);
    send_item(1'b1, $urandom, la, ld);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    retire_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_retires.size() == 0) begin
        $error("unexpected item: pc_after %h", pc_after);
        fail_count++;
      end else begin
        e = pending_retires.pop_front();
        if (pc_after !== e.pc) begin
          $error("pc_after exp %h got %h", e.pc, pc_after); fail_count++;
        end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); fail_count++;
        end
        if (reg_written !== e.wr) begin
          $error("reg_written exp %0d got %0d", e.wr, reg_written); fail_count++;
        end
        if (reg_index !== e.idx) begin
          $error("reg_index exp %0d got %0d", e.idx, reg_index); fail_count++;
        end
        if (reg_value !== e.val) begin
          $error("reg_value exp %h got %h", e.val, reg_value); fail_count++;
        end
      end
    end
  end

  // receiver stalls: random, or a long counted hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 36);
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_loader;
    loader_write(12'd0, 32'h8000_80F1);
    loader_write(12'd4092, 32'hFFFF_FFFF);
    loader_write(12'd4094, 32'h1234_5678);  // misaligned, dropped
  endtask

  task automatic test_alu;
    exec_ins(enc_i(mie_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
    exec_ins(enc_i(mie_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    exec_ins(enc_i(mie_pkg::OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
    exec_ins(enc_r(mie_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));
    exec_ins(enc_r(mie_pkg::FN_SUB, 5'd1, 5'd2, 5'd0, 5'd0));  // $0 stays zero
    exec_ins(enc_r(mie_pkg::FN_SLT, 5'd1, 5'd2, 5'd4, 5'd0));
    exec_ins(enc_r(mie_pkg::FN_SLTU, 5'd1, 5'd2, 5'd5, 5'd0));
    exec_ins(enc_r(mie_pkg::FN_SRA, 5'd0, 5'd1, 5'd6, 5'd31));
    exec_ins(enc_r(mie_pkg::FN_SRLV, 5'd2, 5'd1, 5'd7, 5'd0));
    exec_ins(enc_i(mie_pkg::OP_SLTIU, 5'd0, 5'd8, 16'hFFFF));
  endtask

  task automatic test_memory;
    exec_ins(enc_i(mie_pkg::OP_LB, 5'd0, 5'd9, 16'd0));
    exec_ins(enc_i(mie_pkg::OP_LH, 5'd0, 5'd10, 16'd2));
    exec_ins(enc_i(mie_pkg::OP_LBU, 5'd0, 5'd11, 16'd1));
    exec_ins(enc_i(mie_pkg::OP_LW, 5'd0, 5'd12, 16'd4092));
    exec_ins(enc_i(mie_pkg::OP_LW, 5'd0, 5'd13, 16'd4096));  // out of range
    exec_ins(enc_i(mie_pkg::OP_LHU, 5'd0, 5'd13, 16'd1));    // misaligned
    exec_ins(enc_i(mie_pkg::OP_SH, 5'd0, 5'd1, 16'd6));
  endtask

  task automatic test_control;
    exec_ins(enc_i(mie_pkg::OP_BGTZ, 5'd0, 5'd0, 16'h0010));  // zero is not greater
    exec_ins(enc_i(mie_pkg::OP_BLEZ, 5'd0, 5'd0, 16'hFFF0));
    exec_ins({mie_pkg::OP_JAL, 26'h3FF_FFFF});
    exec_ins(enc_r(mie_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0));
    exec_ins(enc_r(mie_pkg::FN_JALR, 5'd1, 5'd0, 5'd14, 5'd0));
    exec_ins(enc_i(mie_pkg::OP_REGIMM, 5'd1, mie_pkg::RT_BLTZ, 16'h8000));
    exec_ins({mie_pkg::OP_J, 26'h000_0040});
  endtask

  task automatic test_unknown;
    exec_ins(enc_i(6'h22, 5'd0, 5'd1, 16'd0));                   // lwl
    exec_ins(enc_i(mie_pkg::OP_REGIMM, 5'd0, 5'd17, 16'd4));     // bgezal
    exec_ins(enc_r(mie_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd1));    // nonzero shift field
  endtask

  function automatic logic [31:0] random_ins;
    logic [5:0]  alu_fn [12] = '{mie_pkg::FN_SLLV, mie_pkg::FN_SRLV, mie_pkg::FN_SRAV,
                                 mie_pkg::FN_ADD, mie_pkg::FN_ADDU, mie_pkg::FN_SUB,
                                 mie_pkg::FN_SUBU, mie_pkg::FN_AND, mie_pkg::FN_OR,
                                 mie_pkg::FN_XOR, mie_pkg::FN_NOR, mie_pkg::FN_SLT};
    logic [5:0]  mem_op [8] = '{mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LW,
                                mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_SB,
                                mie_pkg::OP_SH, mie_pkg::OP_SW};
    logic [5:0]  op;
    logic [2:0]  size;
    logic [31:0] addr;
    int          pick = $urandom_range(99);
    logic [4:0]  rs = 5'($urandom), rt = 5'($urandom), rd = 5'($urandom);
    if (pick < 20) begin
      return enc_r(($urandom_range(12) == 12) ? mie_pkg::FN_SLTU : alu_fn[$urandom_range(11)],
                   rs, rt, rd, ($urandom_range(19) == 0) ? 5'($urandom) : 5'd0);
    end else if (pick < 28) begin
      return enc_r(($urandom_range(2) == 0) ? mie_pkg::FN_SLL :
                   ($urandom_range(1) == 0) ? mie_pkg::FN_SRL : mie_pkg::FN_SRA,
                   ($urandom_range(9) == 0) ? rs : 5'd0, rt, rd, 5'($urandom));
    end else if (pick < 45) begin
      op = 6'($urandom_range(mie_pkg::OP_ADDI, mie_pkg::OP_LUI));
      return enc_i(op, (op == mie_pkg::OP_LUI && $urandom_range(9) != 0) ? 5'd0 : rs, rt,
                   16'($urandom));
    end else if (pick < 55) begin
      op = 6'($urandom_range(mie_pkg::OP_REGIMM, mie_pkg::OP_BGTZ));
      if (op == mie_pkg::OP_J || op == mie_pkg::OP_JAL) op = mie_pkg::OP_BEQ;
      return enc_i(op, rs, (op >= mie_pkg::OP_BLEZ || op == mie_pkg::OP_REGIMM) ?
                   5'($urandom_range(1)) : rt, 16'($urandom));
    end else if (pick < 60) begin
      case ($urandom_range(3))
        0: return {mie_pkg::OP_J, 26'($urandom)};
        1: return {mie_pkg::OP_JAL, 26'($urandom)};
        2: return enc_r(mie_pkg::FN_JR, rs, 5'd0, 5'd0, 5'd0);
        default: return enc_r(mie_pkg::FN_JALR, rs, 5'd0, rd, 5'd0);
      endcase
    end else begin
      op = mem_op[$urandom_range(7)];
      size = access_size(op);
      if ($urandom_range(3) == 0) return enc_i(op, rs, rt, 16'($urandom));
      if (op inside {mie_pkg::OP_SB, mie_pkg::OP_SH, mie_pkg::OP_SW} ||
          filled_words.size() == 0) begin
        addr = $urandom_range(MEM_BYTES - 1);
        if ($urandom_range(9) != 0) addr = addr & ~(32'(size) - 1);
      end else begin
        addr = filled_words[$urandom_range(filled_words.size() - 1)] +
               ($urandom_range(3) & ~(32'(size) - 1));
      end
      return enc_i(op, 5'd0, rt, addr[15:0]);
    end
  endfunction

  task automatic test_random;
    logic [11:0] la;
    for (int n = 0; n < 1000; n++) begin
      quiet = (n >= 400 && n < 520);
      if ($urandom_range(99) < 12) begin
        la = 12'($urandom);
        if ($urandom_range(9) != 0) la[1:0] = 2'b00;
        loader_write(la, $urandom);
      end else if ($urandom_range(99) < 8) begin
        exec_ins($urandom);
      end else begin
        exec_ins(random_ins());
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    quiet = 1'b1;
    for (int n = 0; n < 40; n++) exec_ins(random_ins());
    quiet = 1'b0;
    drain();
    for (int n = 0; n < 40; n++) exec_ins(random_ins());
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) begin
      mem_byte[i] = '0;
      mem_known[i] = 1'b0;
    end
    arch_pc = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loader();
    test_alu();
    test_memory();
    test_control();
    test_unknown();
    test_random();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
